// ===== rtl/ffba_pkg.sv =====
// Shared types and codes for the first-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned ReqW  = 24;
  localparam int unsigned StatW = 3;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_MEMORY = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NULL_REL  = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_e;

  typedef enum logic {
    CFG_HEAP_START = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_SLOT,
    S_APPEND,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_DONE
  } fsm_e;

endpackage
`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: sequencer, block table and ports.
`timescale 1ns / 1ps
`default_nettype none
// A request is an allocate (mode 0) or a release (mode 1) and yields exactly
// one response of result address and status. The block table lives in a
// memory with one registered read port, so every table entry visited is
// first read and then checked against the key. An allocate walks the list
// for a first fit, then, if it must grow the heap, scans the in-use bits for
// a free slot and appends. A release walks for the address match and then
// merges each following free block, with a read and a check apiece; the size
// and link of the block being released are held in registers meanwhile. A
// zero-size allocate or a null release is answered without a table access.
// The block takes no new request until the response has been taken. No
// clearing pass is needed: only the in-use bits reset, in flip-flops.
// Configuration writes are taken at any time and must be made while the block
// is idle.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request: tdata = {request_size[23:0], release_address[55:24]}, low bit up;
  // tuser = mode
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [55:0]          s_axis_tdata,
  input  wire logic                 s_axis_tuser,
  // response: tdata = {result_address[31:0], status[34:32]}, low bit up,
  // zero padded to 40 bits
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [39:0]               m_axis_tdata,
  // configuration write
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic                 cfg_index_i,
  input  wire logic [AddrW-1:0]     cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam logic [AddrW-1:0] HdrB = AddrW'(HEADER_BYTES);
  localparam logic [AddrW:0]   RoundAdd = (AddrW+1)'(3);

  // table memory: address, size, free mark, link
  logic [AddrW-1:0] mem_addr [MAX_BLOCKS];
  logic [AddrW-1:0] mem_size [MAX_BLOCKS];
  logic             mem_free [MAX_BLOCKS];
  logic [IdxW-1:0]  mem_link [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] in_use_q, in_use_d;

  logic [AddrW-1:0] rd_addr_q, rd_size_q;
  logic             rd_free_q;
  logic [IdxW-1:0]  rd_link_q;
  logic [IdxW-1:0]  rd_idx;

  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  logic [AddrW-1:0] wr_addr, wr_size;
  logic             wr_free;
  logic [IdxW-1:0]  wr_link;
  logic [IdxW-1:0]  wr_link_idx;
  logic             wr_link_en;
  logic             wr_free_en, wr_size_en, wr_addr_en;

  fsm_e state_q, state_d;

  logic             mode_q, mode_d;
  logic [AddrW-1:0] key_q, key_d;     // rounded size or release address
  logic [IdxW-1:0]  cur_q, cur_d;     // walk / slot / merge index
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  first_q, first_d, last_q, last_d;
  logic             empty_q, empty_d;
  logic [AddrW-1:0] heap_end_q, heap_end_d;
  logic             loaded_q, loaded_d;
  logic [AddrW-1:0] hstart_q, hlimit_q;
  logic [AddrW-1:0] res_addr_q, res_addr_d;
  status_e          res_st_q, res_st_d;

  // size and link of the block being released, kept across the merge loop
  logic [AddrW-1:0] hold_size_q, hold_size_d;
  logic [IdxW-1:0]  hold_link_q, hold_link_d;
  logic             merge_ok;

  // shared unit: one 33-bit add feeding one compare
  logic [AddrW:0]   alu_a, alu_b, alu_sum;
  assign alu_sum = alu_a + alu_b;

  // successor is in use and free: absorb it
  assign merge_ok = in_use_q[hold_link_q] && rd_free_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_DONE);
  assign m_axis_tdata  = {5'd0, res_st_q, res_addr_q};

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hstart_q <= '0;
      hlimit_q <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HEAP_START: hstart_q <= cfg_data_i;
        CFG_HEAP_LIMIT: hlimit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (wr_addr_en) mem_addr[wr_idx] <= wr_addr;
      if (wr_size_en) mem_size[wr_idx] <= wr_size;
      if (wr_free_en) mem_free[wr_idx] <= wr_free;
      if (wr_link_en) mem_link[wr_link_idx] <= wr_link;
    end
    rd_addr_q <= mem_addr[rd_idx];
    rd_size_q <= mem_size[rd_idx];
    rd_free_q <= mem_free[rd_idx];
    rd_link_q <= mem_link[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_use_q   <= '0;
      first_q    <= '0;
      last_q     <= '0;
      empty_q    <= 1'b1;
      loaded_q   <= 1'b0;
      heap_end_q <= '0;
      cnt_q      <= '0;
      cur_q      <= '0;
    end else begin
      state_q    <= state_d;
      in_use_q   <= in_use_d;
      first_q    <= first_d;
      last_q     <= last_d;
      empty_q    <= empty_d;
      loaded_q   <= loaded_d;
      heap_end_q <= heap_end_d;
      cnt_q      <= cnt_d;
      cur_q      <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    key_q       <= key_d;
    res_addr_q  <= res_addr_d;
    res_st_q    <= res_st_d;
    hold_size_q <= hold_size_d;
    hold_link_q <= hold_link_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (!s_axis_tuser && s_axis_tdata[ReqW-1:0] == '0) state_d = S_DONE;
          else if (s_axis_tuser && s_axis_tdata[55:24] == '0) state_d = S_DONE;
          else if (empty_q) state_d = s_axis_tuser ? S_DONE : S_SLOT;
          else state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: state_d = S_WALK_CHK;
      S_WALK_CHK: begin
        if (in_use_q[cur_q] && (mode_q ? (rd_addr_q == key_q)
                                       : (rd_free_q && rd_size_q >= key_q)))
          state_d = mode_q ? S_MERGE_RD : S_DONE;
        else if (cur_q == last_q || cnt_q == CntW'(MAX_BLOCKS - 1))
          state_d = mode_q ? S_DONE : S_SLOT;
        else state_d = S_WALK_RD;
      end
      S_SLOT: begin
        if (!in_use_q[cur_q]) state_d = S_APPEND;
        else if (cur_q == IdxW'(MAX_BLOCKS - 1)) state_d = S_DONE;
      end
      S_APPEND: state_d = S_DONE;
      S_MERGE_RD: state_d = (cur_q == last_q) ? S_DONE : S_MERGE_CHK;
      S_MERGE_CHK: state_d = merge_ok ? S_MERGE_RD : S_DONE;
      S_DONE: if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_d      = mode_q;
    key_d       = key_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    last_d      = last_q;
    empty_d     = empty_q;
    heap_end_d  = heap_end_q;
    loaded_d    = loaded_q;
    in_use_d    = in_use_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    hold_size_d = hold_size_q;
    hold_link_d = hold_link_q;
    rd_idx      = cur_q;
    wr_en       = 1'b0;
    wr_idx      = cur_q;
    wr_addr     = '0;
    wr_size     = '0;
    wr_free     = 1'b0;
    wr_link     = '0;
    wr_link_idx = cur_q;
    wr_addr_en  = 1'b0;
    wr_size_en  = 1'b0;
    wr_free_en  = 1'b0;
    wr_link_en  = 1'b0;
    alu_a       = '0;
    alu_b       = '0;
    case (state_q)
      S_IDLE: begin
        mode_d     = s_axis_tuser;
        // round size up to four bytes
        alu_a      = (AddrW+1)'(s_axis_tdata[ReqW-1:0]);
        alu_b      = RoundAdd;
        key_d      = s_axis_tuser ? s_axis_tdata[55:24] : {alu_sum[AddrW-1:2], 2'b00};
        cur_d      = first_q;
        cnt_d      = '0;
        res_addr_d = '0;
        if (s_axis_tuser)
          res_st_d = (s_axis_tdata[55:24] == '0) ? ST_NULL_REL : ST_UNKNOWN;
        else
          res_st_d = (s_axis_tdata[ReqW-1:0] == '0) ? ST_ZERO_SIZE : ST_NO_MEMORY;
        if (s_axis_tvalid && !s_axis_tuser && s_axis_tdata[ReqW-1:0] != '0 && empty_q) begin
          cur_d = '0;
          if (!loaded_q) begin
            heap_end_d = hstart_q;
            loaded_d   = 1'b1;
          end
        end
      end
      S_WALK_CHK: begin
        if (in_use_q[cur_q] && (mode_q ? (rd_addr_q == key_q)
                                       : (rd_free_q && rd_size_q >= key_q))) begin
          wr_en      = 1'b1;
          wr_free_en = 1'b1;
          wr_free    = mode_q;
          if (mode_q) begin
            res_st_d    = ST_RELEASED;
            hold_size_d = rd_size_q;
            hold_link_d = rd_link_q;
          end else begin
            res_st_d   = ST_ALLOCATED;
            res_addr_d = rd_addr_q;
          end
        end else if (cur_q == last_q || cnt_q == CntW'(MAX_BLOCKS - 1)) begin
          if (!mode_q) begin
            cur_d = '0;
            if (!loaded_q) begin
              heap_end_d = hstart_q;
              loaded_d   = 1'b1;
            end
          end
        end else begin
          cur_d = rd_link_q;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SLOT: begin
        if (in_use_q[cur_q]) cur_d = cur_q + 1'b1;
        // end of heap after the new block, no wrap
        alu_a = {1'b0, heap_end_q} + {1'b0, HdrB};
        alu_b = {1'b0, key_q};
      end
      S_APPEND: begin
        alu_a = {1'b0, heap_end_q} + {1'b0, HdrB};
        alu_b = {1'b0, key_q};
        if (alu_sum <= {1'b0, hlimit_q}) begin
          wr_en      = 1'b1;
          wr_addr_en = 1'b1;
          wr_size_en = 1'b1;
          wr_free_en = 1'b1;
          wr_addr    = heap_end_q + HdrB;
          wr_size    = key_q;
          in_use_d[cur_q] = 1'b1;
          if (empty_q) begin
            first_d = cur_q;
            empty_d = 1'b0;
          end else begin
            // chain the new block behind the old tail
            wr_link_en  = 1'b1;
            wr_link_idx = last_q;
            wr_link     = cur_q;
          end
          last_d     = cur_q;
          heap_end_d = alu_sum[AddrW-1:0];
          res_addr_d = heap_end_q + HdrB;
          res_st_d   = ST_ALLOCATED;
        end
      end
      S_MERGE_RD: begin
        // cur_q is the block being released; fetch its successor
        rd_idx = hold_link_q;
      end
      S_MERGE_CHK: begin
        if (merge_ok) begin
          // absorb the successor: header plus its payload, wrapping at 32 bits
          alu_a       = {1'b0, hold_size_q} + {1'b0, HdrB};
          alu_b       = {1'b0, rd_size_q};
          wr_en       = 1'b1;
          wr_size_en  = 1'b1;
          wr_size     = alu_sum[AddrW-1:0];
          wr_link_en  = 1'b1;
          wr_link_idx = cur_q;
          wr_link     = rd_link_q;
          hold_size_d = alu_sum[AddrW-1:0];
          hold_link_d = rd_link_q;
          in_use_d[hold_link_q] = 1'b0;
          if (hold_link_q == last_q) last_d = cur_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
